// ===== design/nixie_mux_animator_defines.svh =====
// ----------------------------------------------------------------------------
// nixie_mux_animator_defines.svh
// Assertion macros shared by the nixie multiplexer RTL.
// ----------------------------------------------------------------------------
`ifndef NIXIE_MUX_ANIMATOR_DEFINES_SVH
`define NIXIE_MUX_ANIMATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset
`define NMA_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, checked outside reset
`define NMA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define NMA_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define NMA_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

// ===== design/nma_pkg.sv =====
// ----------------------------------------------------------------------------
// nma_pkg
// Types, constants and digit animation helpers for the nixie multiplexer.
// ----------------------------------------------------------------------------
package nma_pkg;

    localparam int NUM_TUBES  = 3;
    localparam int TUBE_W     = 2;    // active tube index width
    localparam int SEL_W      = 3;    // tube select lines
    localparam int DIGIT_W    = 8;
    localparam int BCD_W      = 4;
    localparam int LEVEL_W    = 8;
    localparam int LED_N      = 3;
    localparam int PLACE_W    = 4;
    localparam int STYLE_W    = 2;
    localparam int SPEED_W    = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [TUBE_W-1:0]  LAST_TUBE   = TUBE_W'(NUM_TUBES - 1);
    localparam logic [SEL_W-1:0]   SEL_NONE    = '1;
    localparam logic [LEVEL_W-1:0] PWM_TOP     = '1;
    localparam logic [LEVEL_W-1:0] PWM_WRAP    = LEVEL_W'(2);
    localparam logic [STYLE_W-1:0] STYLE_RESET = STYLE_W'(2);
    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(8);
    localparam logic [DIGIT_W-1:0] DIGIT_OFF   = DIGIT_W'(10);

    typedef enum logic [1:0] {
        MODE_TARGET = 2'd0,
        MODE_LEDS   = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_LOOP   = 2'd3
    } t_mode;

    typedef enum logic [STYLE_W-1:0] {
        STYLE_NONE  = 2'd0,
        STYLE_STEP  = 2'd1,
        STYLE_LEVEL = 2'd2,
        STYLE_ALT   = 2'd3     // behaves as none
    } t_style;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STYLE = 1'b0,
        CFG_SPEED = 1'b1
    } t_cfg_addr;

    typedef struct packed {
        logic [STYLE_W-1:0] style;
        logic [SPEED_W-1:0] speed;
    } t_cfg;

    typedef struct packed {
        logic [LED_N-1:0] led_pins;
        logic [SEL_W-1:0] tube_enable_n;
        logic [BCD_W-1:0] digit_code;
    } t_result;

    // Place along the electrode depth order; unknown digits sit at off
    function automatic logic [PLACE_W-1:0] place_of(input logic [DIGIT_W-1:0] v);
        logic [PLACE_W-1:0] p;
        case (v)
            8'd1:    p = 4'd1;
            8'd2:    p = 4'd2;
            8'd6:    p = 4'd3;
            8'd7:    p = 4'd4;
            8'd5:    p = 4'd5;
            8'd0:    p = 4'd6;
            8'd4:    p = 4'd7;
            8'd9:    p = 4'd8;
            8'd8:    p = 4'd9;
            8'd3:    p = 4'd10;
            default: p = 4'd0;
        endcase
        return p;
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_at(input logic [PLACE_W-1:0] p);
        logic [DIGIT_W-1:0] d;
        case (p)
            4'd1:    d = 8'd1;
            4'd2:    d = 8'd2;
            4'd3:    d = 8'd6;
            4'd4:    d = 8'd7;
            4'd5:    d = 8'd5;
            4'd6:    d = 8'd0;
            4'd7:    d = 8'd4;
            4'd8:    d = 8'd9;
            4'd9:    d = 8'd8;
            4'd10:   d = 8'd3;
            default: d = DIGIT_OFF;
        endcase
        return d;
    endfunction

    // One animation step of a shown digit towards its target
    function automatic logic [DIGIT_W-1:0] anim_next(input logic [STYLE_W-1:0] style,
                                                    input logic [DIGIT_W-1:0] cur,
                                                    input logic [DIGIT_W-1:0] tgt);
        logic [PLACE_W-1:0] cp;
        logic [PLACE_W-1:0] tp;
        logic [DIGIT_W-1:0] nxt;
        cp  = place_of(cur);
        tp  = place_of(tgt);
        nxt = cur;
        case (t_style'(style))
            STYLE_STEP: begin
                if (cur > tgt) begin
                    nxt = cur - DIGIT_W'(1);
                end else if (cur < tgt) begin
                    nxt = cur + DIGIT_W'(1);
                end
            end
            STYLE_LEVEL: begin
                if (cp > tp) begin
                    nxt = digit_at(cp - PLACE_W'(1));
                end else if (cp < tp) begin
                    nxt = digit_at(cp + PLACE_W'(1));
                end
            end
            default: nxt = tgt;
        endcase
        return nxt;
    endfunction

endpackage

// ===== design/nixie_mux_animator.sv =====
// ----------------------------------------------------------------------------
// nixie_mux_animator
// Multiplexed nixie driver with per-tube RGB LED PWM and digit animation.
// ----------------------------------------------------------------------------
//
//  channel   | ports                         | payload, lowest bit first
//  ----------+-------------------------------+-------------------------------
//  event in  | s_axis_tvalid/tready/tdata/   | tuser: mode[1:0]
//            | tuser                         | tdata: tube, value_a, value_b,
//            |                               |        value_c (32 bits)
//  pins out  | m_axis_tvalid/tready/tdata    | tdata: digit_code[3:0],
//            |                               |   tube_enable_n[6:4],
//            |                               |   led_pins[9:7], zero to 15
//  config    | i_cfg_we/addr/wdata           | 0 anim_style, 1 anim_speed
//
//  One event per clock while tready is high; each yields one pin result,
//  registered. All state update is a single pass of logic.
//  Synchronous active-low reset; no clearing pass, all state in flops.
//  A stalled output keeps one result in the skid entry; tready then drops
//  until the output register drains.
//
module nixie_mux_animator
    import nma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // event input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // tube, value_a, value_b, value_c
    input  logic [1:0]            s_axis_tuser,  // mode
    // pin result output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // digit_code, tube_enable_n, led_pins
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    t_result w_core_res;
    t_result w_out_res;
    logic    w_accept;

    // Config registers; a zero speed write is dropped so the divider
    // compare never sees zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.style <= STYLE_RESET;
            r_cfg.speed <= SPEED_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_STYLE: r_cfg.style <= i_cfg_wdata[STYLE_W-1:0];
                CFG_SPEED: begin
                    if (i_cfg_wdata[SPEED_W-1:0] != '0) begin
                        r_cfg.speed <= i_cfg_wdata[SPEED_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    nma_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_mode    (s_axis_tuser),
        .i_tube    (s_axis_tdata[7:0]),
        .i_value_a (s_axis_tdata[15:8]),
        .i_value_b (s_axis_tdata[23:16]),
        .i_value_c (s_axis_tdata[31:24]),
        .i_cfg     (r_cfg),
        .o_result  (w_core_res)
    );

    // result register plus skid entry
    nma_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (w_core_res),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (w_out_res)
    );

    assign m_axis_tdata = {6'b0, w_out_res.led_pins, w_out_res.tube_enable_n,
                           w_out_res.digit_code};

endmodule

// ===== design/nma_core.sv =====
// ----------------------------------------------------------------------------
// nma_core
// Tube state, multiplex rotation, LED PWM compare and digit animation.
// ----------------------------------------------------------------------------
`include "nixie_mux_animator_defines.svh"

module nma_core
    import nma_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_tube,
    input  logic [7:0]          i_value_a,
    input  logic [7:0]          i_value_b,
    input  logic [7:0]          i_value_c,
    input  t_cfg                i_cfg,
    output t_result             o_result
);

    logic [DIGIT_W-1:0] r_target [NUM_TUBES];
    logic [DIGIT_W-1:0] n_target [NUM_TUBES];
    logic [DIGIT_W-1:0] r_shown  [NUM_TUBES];
    logic [DIGIT_W-1:0] n_shown  [NUM_TUBES];
    logic [LEVEL_W-1:0] r_level  [NUM_TUBES][LED_N];
    logic [LEVEL_W-1:0] n_level  [NUM_TUBES][LED_N];
    logic [TUBE_W-1:0]  r_active, n_active;
    logic [LEVEL_W-1:0] r_pwm, n_pwm;
    logic               r_mux_due, n_mux_due;
    logic               r_anim_due, n_anim_due;
    logic [SPEED_W-1:0] r_tick_div, n_tick_div;
    logic [BCD_W-1:0]   r_digit, n_digit;
    logic [SEL_W-1:0]   r_select, n_select;
    logic [LED_N-1:0]   r_led, n_led;

    logic               w_tube_ok;
    logic [TUBE_W-1:0]  w_tidx;
    logic [TUBE_W-1:0]  w_act;

    assign w_tube_ok = (i_tube < 8'(NUM_TUBES));
    assign w_tidx    = i_tube[TUBE_W-1:0];

    always_comb begin
        n_target   = r_target;
        n_shown    = r_shown;
        n_level    = r_level;
        n_active   = r_active;
        n_pwm      = r_pwm;
        n_mux_due  = r_mux_due;
        n_anim_due = r_anim_due;
        n_tick_div = r_tick_div;
        n_digit    = r_digit;
        n_select   = r_select;
        n_led      = r_led;
        w_act      = r_active;
        if (r_mux_due) begin
            w_act = (r_active < LAST_TUBE) ? r_active + TUBE_W'(1) : '0;
        end
        if (i_accept) begin
            case (t_mode'(i_mode))
                MODE_TARGET: begin
                    if (w_tube_ok) begin
                        n_target[w_tidx] = i_value_a;
                    end
                end
                MODE_LEDS: begin
                    if (w_tube_ok) begin
                        n_level[w_tidx][0] = i_value_a;
                        n_level[w_tidx][1] = i_value_b;
                        n_level[w_tidx][2] = i_value_c;
                    end
                end
                MODE_TICK: begin
                    if (r_tick_div >= i_cfg.speed) begin
                        n_anim_due = 1'b1;
                        n_tick_div = '0;
                    end else begin
                        n_tick_div = r_tick_div + SPEED_W'(1);
                    end
                    n_mux_due = 1'b1;
                end
                MODE_LOOP: begin
                    if (r_mux_due) begin
                        n_digit   = r_shown[w_act][BCD_W-1:0];
                        n_select  = ~(SEL_W'(1) << w_act);
                        n_mux_due = 1'b0;
                    end
                    n_active = w_act;
                    for (int k = 0; k < LED_N; k++) begin
                        n_led[k] = (r_pwm < r_level[w_act][k]);
                    end
                    n_pwm = (r_pwm == PWM_TOP) ? PWM_WRAP : r_pwm + LEVEL_W'(1);
                    if (r_anim_due) begin
                        for (int i = 0; i < NUM_TUBES; i++) begin
                            n_shown[i] = anim_next(i_cfg.style, r_shown[i], r_target[i]);
                        end
                        n_anim_due = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TUBES; i++) begin
                r_target[i] <= '0;
                r_shown[i]  <= '0;
                for (int k = 0; k < LED_N; k++) begin
                    r_level[i][k] <= '0;
                end
            end
            r_active   <= '0;
            r_pwm      <= '0;
            r_mux_due  <= 1'b1;
            r_anim_due <= 1'b0;
            r_tick_div <= '0;
            r_digit    <= '0;
            r_select   <= SEL_NONE;
            r_led      <= '0;
        end else begin
            r_target   <= n_target;
            r_shown    <= n_shown;
            r_level    <= n_level;
            r_active   <= n_active;
            r_pwm      <= n_pwm;
            r_mux_due  <= n_mux_due;
            r_anim_due <= n_anim_due;
            r_tick_div <= n_tick_div;
            r_digit    <= n_digit;
            r_select   <= n_select;
            r_led      <= n_led;
        end
    end

    // result is the pin state after this item
    assign o_result.digit_code    = n_digit;
    assign o_result.tube_enable_n = n_select;
    assign o_result.led_pins      = n_led;

    `NMA_ASSERT_IMPL(a_active_range, i_clk, i_rst_n, 1'b1, r_active <= LAST_TUBE)
    `NMA_ASSERT_IMPL(a_select_one_cold, i_clk, i_rst_n, 1'b1, r_select == SEL_NONE || $countones(r_select) == SEL_W - 1)
    `NMA_ASSERT_NEXT(a_loop_clears_flags, i_clk, i_rst_n, i_accept && i_mode == MODE_LOOP, !r_mux_due && !r_anim_due)

endmodule

// ===== design/nma_skid.sv =====
// ----------------------------------------------------------------------------
// nma_skid
// Result register with one skid entry; ready to the source is registered.
// ----------------------------------------------------------------------------
`include "nixie_mux_animator_defines.svh"

module nma_skid
    import nma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_result i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_in_xfer;
    logic    w_out_free;

    assign o_in_ready = !r_skid_valid;
    assign w_in_xfer  = i_in_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out       <= i_in_data;
                r_out_valid <= w_in_xfer;
            end
        end else if (w_in_xfer) begin
            r_skid       <= i_in_data;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `NMA_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `NMA_ASSERT_NEXT(a_skid_held, i_clk, i_rst_n, r_skid_valid && !i_out_ready, r_skid_valid)
    `NMA_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, w_in_xfer && r_out_valid && !i_out_ready, r_skid_valid)

endmodule

// ===== bench/tb_nixie_mux_animator.sv =====
// ----------------------------------------------------------------------------
// tb_nixie_mux_animator
// Self-checking bench for the nixie multiplexer: events in on the slave
// stream, pin words out on the master stream, compared against an in-bench
// model of tube rotation, LED PWM and digit animation.
// ----------------------------------------------------------------------------
module tb_nixie_mux_animator;
    timeunit 1ns;
    timeprecision 1ps;

    import nma_pkg::*;

    // Electrode stack from the back of the tube to the front; place 0 is off
    localparam logic [7:0] ELECTRODE_ORDER [0:10] = '{8'd10, 8'd1, 8'd2, 8'd6, 8'd7,
                                                      8'd5, 8'd0, 8'd4, 8'd9, 8'd8, 8'd3};

    localparam int N_PHASES     = 7;
    localparam int PHASE_EVENTS = 250;
    localparam int FLOOD_EVENTS = 30;
    localparam int HOLD_CYCLES  = 300;

    // Register settings per phase, extremes included. Phase 4 writes a zero
    // speed, which the block must ignore, so the speed of phase 3 stays.
    localparam t_style     PHASE_STYLE [0:N_PHASES-1] = '{STYLE_NONE, STYLE_STEP,
        STYLE_LEVEL, STYLE_ALT, STYLE_LEVEL, STYLE_STEP, STYLE_LEVEL};
    localparam logic [7:0] PHASE_SPEED [0:N_PHASES-1] = '{8'd1, 8'd1, 8'd2, 8'd4,
        8'd0, 8'd255, 8'd1};

    // ------------------------------------------------------------------------
    // Pin tracker: mirrors the tube state, predicts the pin word for every
    // event transfer and checks the pin words as they leave the block.
    // ------------------------------------------------------------------------
    class pin_tracker;
        t_style      style;
        logic [7:0]  speed;
        logic [7:0]  target [NUM_TUBES];
        logic [7:0]  shown [NUM_TUBES];
        logic [7:0]  level [NUM_TUBES*LED_N];
        logic [1:0]  active;
        logic [7:0]  pwm;
        bit          mux_due;
        bit          anim_due;
        logic [7:0]  divider;
        t_result     pins;
        t_result     pending_pins [$];
        int          fail_count;

        function new();
            style    = STYLE_LEVEL;
            speed    = 8'd8;
            foreach (target[i]) target[i] = '0;
            foreach (shown[i]) shown[i] = '0;
            foreach (level[i]) level[i] = '0;
            active   = '0;
            pwm      = '0;
            mux_due  = 1'b1;
            anim_due = 1'b0;
            divider  = '0;
            pins.digit_code    = '0;
            pins.tube_enable_n = SEL_NONE;
            pins.led_pins      = '0;
            fail_count = 0;
        endfunction

        function void write_reg(t_cfg_addr addr, logic [7:0] data);
            case (addr)
                CFG_STYLE: style = t_style'(data[1:0]);
                default:   if (data != 8'd0) speed = data;
            endcase
        endfunction

        function int rank_of(logic [7:0] d);
            for (int p = 10; p > 0; p--) begin
                if (ELECTRODE_ORDER[p] == d) return p;
            end
            return 0;
        endfunction

        function void animate_digits();
            logic [7:0] cur;
            logic [7:0] tgt;
            int         cp;
            int         tp;
            for (int i = 0; i < NUM_TUBES; i++) begin
                cur = shown[i];
                tgt = target[i];
                case (style)
                    STYLE_STEP: begin
                        if (cur > tgt) shown[i] = cur - 8'd1;
                        else if (cur < tgt) shown[i] = cur + 8'd1;
                    end
                    STYLE_LEVEL: begin
                        cp = rank_of(cur);
                        tp = rank_of(tgt);
                        if (cp > tp) shown[i] = ELECTRODE_ORDER[cp-1];
                        else if (cp < tp) shown[i] = ELECTRODE_ORDER[cp+1];
                    end
                    default: shown[i] = tgt;
                endcase
            end
        endfunction

        // One event transfer: update the state and queue the pin word
        function void take_event(t_mode mode, logic [7:0] tube, logic [7:0] va,
                                 logic [7:0] vb, logic [7:0] vc);
            case (mode)
                MODE_TARGET: if (tube < NUM_TUBES) target[tube] = va;
                MODE_LEDS: begin
                    if (tube < NUM_TUBES) begin
                        level[tube*3]     = va;
                        level[tube*3 + 1] = vb;
                        level[tube*3 + 2] = vc;
                    end
                end
                MODE_TICK: begin
                    if (divider >= speed) begin
                        anim_due = 1'b1;
                        divider  = '0;
                    end else begin
                        divider = divider + 8'd1;
                    end
                    mux_due = 1'b1;
                end
                default: begin
                    if (mux_due) begin
                        active = (active == LAST_TUBE) ? 2'd0 : active + 2'd1;
                        pins.digit_code    = shown[active][3:0];
                        pins.tube_enable_n = ~(3'b001 << active);
                        mux_due = 1'b0;
                    end
                    for (int k = 0; k < LED_N; k++)
                        pins.led_pins[k] = (pwm < level[active*3 + k]);
                    pwm = (pwm == 8'hFF) ? 8'd2 : pwm + 8'd1;
                    if (anim_due) begin
                        animate_digits();
                        anim_due = 1'b0;
                    end
                end
            endcase
            pending_pins.push_back(pins);
        endfunction

        function void check_pins(logic [15:0] word);
            t_result want;
            t_result got;
            got = t_result'(word[9:0]);
            if (pending_pins.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: pin word %h with nothing outstanding", $realtime, word);
                return;
            end
            want = pending_pins.pop_front();
            if (got.digit_code != want.digit_code ||
                got.tube_enable_n != want.tube_enable_n ||
                got.led_pins != want.led_pins || word[15:10] != '0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: pins digit/sel/led/pad want %h/%b/%b/00 got %h/%b/%b/%h",
                             $realtime, want.digit_code, want.tube_enable_n,
                             want.led_pins, got.digit_code, got.tube_enable_n,
                             got.led_pins, word[15:10]);
            end
        endfunction

        function int pending();
            return pending_pins.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;  // tube, value_a, value_b, value_c
    logic [1:0]            s_axis_tuser = '0;  // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;       // digit_code, tube_enable_n, led_pins
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    nixie_mux_animator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    pin_tracker tracker;
    bit         src_idling  = 1'b1;
    bit         sink_idling = 1'b1;
    bit         hold_request = 1'b0;   // main flow asks the sink for a long hold-off
    bit         hold_active  = 1'b0;
    bit         out_of_reset = 1'b0;

    // Both streams are sampled at the edge, before the block's own updates
    // land, so every transfer is seen with the values that were accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_pins(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_event(t_mode'(s_axis_tuser), s_axis_tdata[7:0],
                                   s_axis_tdata[15:8], s_axis_tdata[23:16],
                                   s_axis_tdata[31:24]);
        end
    end

    // Sink: random stalls, ready stretches, and one long hold-off on request.
    // Each branch drives tready once and then waits on the clock before it picks again.
    initial begin
        wait (out_of_reset);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
            end else if (sink_idling && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Register write; the enable is raised and lowered on separate clock edges,
    // so back-to-back calls never raise and lower the enable within one step.
    task automatic write_reg(t_cfg_addr addr, logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        tracker.write_reg(addr, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one event and hold it until the transfer. valid stays high
    // between back-to-back events and only drops for a gap.
    task automatic send_event(t_mode mode, logic [7:0] tube, logic [7:0] va,
                              logic [7:0] vb, logic [7:0] vc);
        if (src_idling && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {vc, vb, va, tube};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [7:0] random_level();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly ticks and loop passes with in-range writes, some noise
    task automatic send_random_event();
        int         pick;
        t_mode      mode;
        logic [7:0] tube;
        logic [7:0] va;
        logic [7:0] vb;
        logic [7:0] vc;
        pick = $urandom_range(0, 99);
        if (pick < 15)      mode = MODE_TARGET;
        else if (pick < 25) mode = MODE_LEDS;
        else if (pick < 60) mode = MODE_TICK;
        else                mode = MODE_LOOP;
        tube = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, NUM_TUBES - 1))
                                            : 8'($urandom_range(0, 255));
        va = random_level();
        vb = random_level();
        vc = random_level();
        // target digits mostly real digits or the off code
        if (mode == MODE_TARGET && $urandom_range(0, 3) != 0)
            va = 8'($urandom_range(0, 10));
        send_event(mode, tube, va, vb, vc);
    endtask

    // Stop offering and let every outstanding pin word come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    initial begin
        int waited;
        tracker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        out_of_reset = 1'b1;

        // Directed: reset settings (level style, speed 8)
        send_event(MODE_LOOP, 8'd0, 8'd0, 8'd0, 8'd0);       // first pass rotates
        send_event(MODE_TARGET, 8'd0, 8'd3, 8'hFF, 8'hFF);   // deepest electrode
        send_event(MODE_TARGET, 8'd1, 8'd9, 8'd0, 8'd0);
        send_event(MODE_TARGET, 8'd2, 8'hFF, 8'd0, 8'd0);    // not a digit, counts as off
        send_event(MODE_TARGET, 8'd3, 8'd5, 8'd0, 8'd0);     // tube out of range
        send_event(MODE_TARGET, 8'hFF, 8'd7, 8'd0, 8'd0);
        send_event(MODE_LEDS, 8'd0, 8'hFF, 8'h00, 8'h80);
        send_event(MODE_LEDS, 8'd1, 8'd1, 8'd2, 8'd3);
        send_event(MODE_LEDS, 8'd2, 8'hFF, 8'hFF, 8'hFF);
        send_event(MODE_LEDS, 8'hFF, 8'h00, 8'h00, 8'h00);   // ignored
        repeat (9) send_event(MODE_TICK, 8'hA5, 8'h5A, 8'hC3, 8'h3C); // divider fires
        repeat (6) send_event(MODE_LOOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_reg(CFG_STYLE, {6'($urandom_range(0, 63)), PHASE_STYLE[ph]});
            write_reg(CFG_SPEED, PHASE_SPEED[ph]);
            if (ph == N_PHASES - 1) begin
                src_idling  = 1'b0;
                sink_idling = 1'b0;
            end
            if (ph == 2) begin
                // Long sink hold-off while the source keeps offering: the
                // result path fills and the input must stall.
                hold_request = 1'b1;
                wait (hold_active);
                src_idling = 1'b0;
                repeat (FLOOD_EVENTS) send_random_event();
                src_idling = 1'b1;
            end
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if (ph != N_PHASES - 1 && n % 64 == 0) begin
                    src_idling  = ($urandom_range(0, 3) != 0);
                    sink_idling = ($urandom_range(0, 3) != 0);
                end
                send_random_event();
            end
            drain();
        end

        // Final drain with a bound; anything still outstanding is a failure
        waited = 0;
        while (tracker.pending() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (tracker.fail_count + tracker.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/nma_pkg.sv
design/nma_core.sv
design/nma_skid.sv
design/nixie_mux_animator.sv
bench/tb_nixie_mux_animator.sv
